@@ sv/fpa_pkg.sv @@
// Shared types and constants for the page-frame allocator.
package fpa_pkg;

	localparam int ID_W    = 16;
	localparam int LEN_W   = 20;
	localparam int ST_W    = 3;
	localparam int PIDX_W  = 6;
	localparam int NEED_W  = 7;
	localparam int TOT_W   = 21;

	localparam logic [ST_W-1:0] ST_ASSIGNED   = 3'd0;
	localparam logic [ST_W-1:0] ST_FREED      = 3'd1;
	localparam logic [ST_W-1:0] ST_NO_SPACE   = 3'd2;
	localparam logic [ST_W-1:0] ST_Q_EMPTY    = 3'd3;
	localparam logic [ST_W-1:0] ST_Q_FULL     = 3'd4;
	localparam logic [ST_W-1:0] ST_NONE_FREED = 3'd5;

	typedef struct packed {
		logic              is_free;
		logic [ID_W-1:0]   id;
		logic [NEED_W-1:0] need;
	} cmd_t;

endpackage

@@ sv/fpa_if.sv @@
// Request and result channel interfaces of the page-frame allocator.
interface fpa_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] process_id;
	logic [19:0] content_bytes;

	modport source(output valid, output req_type, output process_id, output content_bytes,
		input ready);
	modport sink(input valid, input req_type, input process_id, input content_bytes,
		output ready);
endinterface

interface fpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  page_index;
	logic [15:0] owner_id;
	logic        last;

	modport source(output valid, output status, output page_index, output owner_id,
		output last, input ready);
	modport sink(input valid, input status, input page_index, input owner_id,
		input last, output ready);
endinterface

@@ sv/fpa_front.sv @@
// Front end: accepts requests and works out the page count of each allocation.
module fpa_front #(
	parameter int NUM_PAGES  = 64,
	parameter int PAGE_BYTES = 4096,
	parameter int ID_BYTES   = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	fpa_req_if.sink       req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output fpa_pkg::cmd_t cmd
);

	localparam int ACC_MAX = (NUM_PAGES + 1) * PAGE_BYTES;
	localparam int ACC_W   = $clog2(ACC_MAX + 1);
	localparam int W       = (ACC_W > fpa_pkg::TOT_W) ? ACC_W : fpa_pkg::TOT_W;

	logic          busy_q;
	logic          cmd_valid_q;
	fpa_pkg::cmd_t cmd_q;
	logic [W-1:0]  total_q;
	logic [W-1:0]  acc_q;
	logic          done;

	assign req.ready = !busy_q && !cmd_valid_q;
	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;
	assign done      = (acc_q >= total_q) ||
		(cmd_q.need == fpa_pkg::NEED_W'(NUM_PAGES + 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cmd_valid_q <= 1'b0;
		end else begin
			if (cmd_valid_q && cmd_ready) begin
				cmd_valid_q <= 1'b0;
			end
			if (req.valid && req.ready) begin
				cmd_q.id   <= req.process_id;
				cmd_q.need <= '0;
				if (req.req_type) begin
					cmd_q.is_free <= 1'b1;
					cmd_valid_q   <= 1'b1;
				end else begin
					cmd_q.is_free <= 1'b0;
					total_q       <= W'(req.content_bytes) + W'(ID_BYTES);
					acc_q         <= '0;
					busy_q        <= 1'b1;
				end
			end else if (busy_q) begin
				if (done) begin
					busy_q      <= 1'b0;
					cmd_valid_q <= 1'b1;
				end else begin
					acc_q      <= acc_q + W'(PAGE_BYTES);
					cmd_q.need <= cmd_q.need + fpa_pkg::NEED_W'(1);
				end
			end
		end
	end

endmodule

@@ sv/fpa_cmd_fifo.sv @@
// Two-entry command queue between the front end and the page engine.
module fpa_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fpa_pkg::cmd_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output fpa_pkg::cmd_t out_data
);

	fpa_pkg::cmd_t entry_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = entry_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				entry_q[wr_q] <= in_data;
				wr_q          <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ sv/fpa_back.sv @@
// Page engine: free bitmap, owner tags, admission queue and result register.
module fpa_back #(
	parameter int NUM_PAGES   = 64,
	parameter int QUEUE_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  fpa_pkg::cmd_t cmd,
	fpa_rsp_if.source     rsp
);

	localparam int PG_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CNT_W = $clog2(NUM_PAGES + 1);
	localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int NW    = fpa_pkg::NEED_W;
	localparam int IW    = fpa_pkg::ID_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALLOC,
		S_FREE_ID,
		S_FREE
	} state_t;

	state_t                    state_q;
	logic [NUM_PAGES-1:0]      page_free_q;
	logic [CNT_W-1:0]          free_cnt_q;
	logic [QA_W-1:0]           head_q;
	logic [QA_W-1:0]           tail_q;
	logic [QC_W-1:0]           qcnt_q;
	logic [IW-1:0]             id_q;
	logic [NW-1:0]             need_q;
	logic [CNT_W-1:0]          k_q;
	logic [CNT_W-1:0]          idx_q;
	logic [PG_W-1:0]           pg_s1;
	logic                      v_s1;
	logic                      pend_v_q;
	logic [PG_W-1:0]           pend_pg_q;
	logic                      out_valid_q;
	logic [fpa_pkg::ST_W-1:0]  out_status_q;
	logic [fpa_pkg::PIDX_W-1:0] out_page_q;
	logic [IW-1:0]             out_owner_q;
	logic                      out_last_q;

	logic [IW-1:0]             owner_mem [NUM_PAGES];
	logic [IW-1:0]             queue_mem [QUEUE_DEPTH];
	logic [IW-1:0]             owner_rd_q;
	logic [IW-1:0]             queue_rd_q;

	logic                      adv;
	logic [PG_W-1:0]           cur_pg;
	logic                      cur_free;
	logic                      idx_end;
	logic [PG_W-1:0]           rd_addr;
	logic                      owner_we;
	logic                      queue_we;
	logic                      match;
	logic                      alloc_ok;
	logic                      last_page;
	logic                      emit;

	assign adv       = !out_valid_q || rsp.ready;
	assign cmd_ready = (state_q == S_IDLE) && adv;
	assign cur_pg    = idx_q[PG_W-1:0];
	assign cur_free  = page_free_q[cur_pg];
	assign idx_end   = (idx_q == CNT_W'(NUM_PAGES));
	assign rd_addr   = (adv && !idx_end) ? cur_pg : pg_s1;
	assign owner_we  = (state_q == S_ALLOC) && cur_free && adv;
	assign alloc_ok  = (qcnt_q != QC_W'(QUEUE_DEPTH)) && (cmd.need <= NW'(free_cnt_q));
	assign queue_we  = cmd_valid && cmd_ready && !cmd.is_free && alloc_ok;
	assign match     = v_s1 && !page_free_q[pg_s1] && (owner_rd_q == id_q);
	assign last_page = ((NW'(k_q) + NW'(1)) == need_q);

	always_comb begin
		unique case (state_q)
			S_IDLE:  emit = cmd_valid && cmd_ready &&
				(cmd.is_free ? (qcnt_q == '0) : !alloc_ok);
			S_ALLOC: emit = cur_free && adv;
			S_FREE:  emit = adv && ((idx_end && !v_s1) || (match && pend_v_q));
			default: emit = 1'b0;
		endcase
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.page_index = out_page_q;
	assign rsp.owner_id   = out_owner_q;
	assign rsp.last       = out_last_q;

	always_ff @(posedge clk) begin
		if (owner_we) begin
			owner_mem[cur_pg] <= id_q;
		end
		owner_rd_q <= owner_mem[rd_addr];
		if (queue_we) begin
			queue_mem[tail_q] <= cmd.id;
		end
		queue_rd_q <= queue_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			page_free_q <= '1;
			free_cnt_q  <= CNT_W'(NUM_PAGES);
			head_q      <= '0;
			tail_q      <= '0;
			qcnt_q      <= '0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			pend_v_q    <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !rsp.ready);
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						id_q   <= cmd.id;
						need_q <= cmd.need;
						k_q    <= '0;
						idx_q  <= '0;
						if (!cmd.is_free) begin
							if (qcnt_q == QC_W'(QUEUE_DEPTH)) begin
								out_status_q <= fpa_pkg::ST_Q_FULL;
								out_page_q   <= '0;
								out_owner_q  <= cmd.id;
								out_last_q   <= 1'b1;
							end else if (!alloc_ok) begin
								out_status_q <= fpa_pkg::ST_NO_SPACE;
								out_page_q   <= '0;
								out_owner_q  <= cmd.id;
								out_last_q   <= 1'b1;
							end else begin
								tail_q  <= (tail_q == QA_W'(QUEUE_DEPTH - 1)) ?
									'0 : tail_q + QA_W'(1);
								qcnt_q  <= qcnt_q + QC_W'(1);
								state_q <= S_ALLOC;
							end
						end else begin
							if (qcnt_q == '0) begin
								out_status_q <= fpa_pkg::ST_Q_EMPTY;
								out_page_q   <= '0;
								out_owner_q  <= '0;
								out_last_q   <= 1'b1;
							end else begin
								head_q  <= (head_q == QA_W'(QUEUE_DEPTH - 1)) ?
									'0 : head_q + QA_W'(1);
								qcnt_q  <= qcnt_q - QC_W'(1);
								state_q <= S_FREE_ID;
							end
						end
					end
				end
				S_ALLOC: begin
					if (cur_free) begin
						if (adv) begin
							page_free_q[cur_pg] <= 1'b0;
							free_cnt_q   <= free_cnt_q - CNT_W'(1);
							k_q          <= k_q + CNT_W'(1);
							idx_q        <= idx_q + CNT_W'(1);
							out_status_q <= fpa_pkg::ST_ASSIGNED;
							out_page_q   <= fpa_pkg::PIDX_W'(cur_pg);
							out_owner_q  <= id_q;
							out_last_q   <= last_page;
							if (last_page) begin
								state_q <= S_IDLE;
							end
						end
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_FREE_ID: begin
					id_q     <= queue_rd_q;
					v_s1     <= 1'b0;
					pend_v_q <= 1'b0;
					state_q  <= S_FREE;
				end
				S_FREE: begin
					if (adv) begin
						if (idx_end && !v_s1) begin
							out_owner_q  <= id_q;
							out_last_q   <= 1'b1;
							if (pend_v_q) begin
								out_status_q <= fpa_pkg::ST_FREED;
								out_page_q   <= fpa_pkg::PIDX_W'(pend_pg_q);
							end else begin
								out_status_q <= fpa_pkg::ST_NONE_FREED;
								out_page_q   <= '0;
							end
							state_q <= S_IDLE;
						end else begin
							if (!idx_end) begin
								v_s1  <= 1'b1;
								pg_s1 <= cur_pg;
								idx_q <= idx_q + CNT_W'(1);
							end else begin
								v_s1 <= 1'b0;
							end
							if (match) begin
								page_free_q[pg_s1] <= 1'b1;
								free_cnt_q <= free_cnt_q + CNT_W'(1);
								pend_v_q   <= 1'b1;
								pend_pg_q  <= pg_s1;
								if (pend_v_q) begin
									out_status_q <= fpa_pkg::ST_FREED;
									out_page_q   <= fpa_pkg::PIDX_W'(pend_pg_q);
									out_owner_q  <= id_q;
									out_last_q   <= 1'b0;
								end
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/fifo_page_allocator_core.sv @@
// Page-frame allocator with owner tags and an admission queue of process ids.
// req carries one request per transaction: allocate (req_type 0) asks for
// ceil((content_bytes + ID_BYTES) / PAGE_BYTES) of the lowest free pages and
// admits process_id; free (req_type 1) pops the oldest admitted id and
// releases its pages in ascending order. rsp carries one transaction per page
// assigned or freed, or a single status transaction; last marks the final one.
// The front end takes a request when it is neither counting nor holding a
// command; for an allocation it adds PAGE_BYTES at a time, counting pages
// until they cover content_bytes + ID_BYTES. A two-entry command queue
// decouples it from the page engine, which walks the page table one entry per
// cycle unless a stalled rsp holds it, and takes a new command only in idle.
// Reset marks every page free and empties the admission queue; no clearing
// pass is needed. When rsp is stalled the result register holds, a free walk
// stops and an allocation walk stops at its next free page; further requests
// are taken until the command queue fills.
module fifo_page_allocator_core #(
	parameter int NUM_PAGES   = 64,
	parameter int PAGE_BYTES  = 4096,
	parameter int QUEUE_DEPTH = 64,
	parameter int ID_BYTES    = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	fpa_req_if.sink   req,
	fpa_rsp_if.source rsp
);

	logic          fr_valid;
	logic          fr_ready;
	fpa_pkg::cmd_t fr_cmd;
	logic          bk_valid;
	logic          bk_ready;
	fpa_pkg::cmd_t bk_cmd;

	fpa_front #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_BYTES(PAGE_BYTES),
		.ID_BYTES  (ID_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd_valid(fr_valid),
		.cmd_ready(fr_ready),
		.cmd      (fr_cmd)
	);

	fpa_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_ready (fr_ready),
		.in_data  (fr_cmd),
		.out_valid(bk_valid),
		.out_ready(bk_ready),
		.out_data (bk_cmd)
	);

	fpa_back #(
		.NUM_PAGES  (NUM_PAGES),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(bk_valid),
		.cmd_ready(bk_ready),
		.cmd      (bk_cmd),
		.rsp      (rsp)
	);

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the page-frame allocator: predicted page results against the core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PAGES   = 64;
	localparam int PAGE_BYTES  = 4096;
	localparam int QUEUE_DEPTH = 64;
	localparam int ID_BYTES    = 4;
	localparam int LIMIT       = 1_500_000;
	localparam int LONG_HOLD   = 400;
	localparam int MAX_REPORTS = 10;

	typedef enum bit {
		REQ_ALLOC   = 1'b0,
		REQ_RELEASE = 1'b1
	} req_kind_t;

	typedef struct {
		req_kind_t                 kind;
		logic [fpa_pkg::ID_W-1:0]  pid;
		logic [fpa_pkg::LEN_W-1:0] len;
	} request_t;

	typedef struct {
		logic [fpa_pkg::ST_W-1:0]   status;
		logic [fpa_pkg::PIDX_W-1:0] page;
		logic [fpa_pkg::ID_W-1:0]   owner;
		logic                       last;
	} page_result_t;

	bit   clk = 1'b0;
	logic arst_n;

	fpa_req_if req_ch();
	fpa_rsp_if rsp_ch();

	fifo_page_allocator_core #(
		.NUM_PAGES(NUM_PAGES),
		.PAGE_BYTES(PAGE_BYTES),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BYTES(ID_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	bit                       page_is_free [NUM_PAGES];
	logic [fpa_pkg::ID_W-1:0] page_tag [NUM_PAGES];
	int                       free_pages;
	logic [fpa_pkg::ID_W-1:0] admit_fifo [QUEUE_DEPTH];
	int                       admit_head;
	int                       admit_tail;
	int                       admit_count;

	request_t                 request_queue[$];
	page_result_t             results_due[$];
	logic [fpa_pkg::ID_W-1:0] recent_ids[$];

	bit req_fire;
	bit offering;
	bit drained;
	bit calm;
	bit long_hold_go;
	bit long_hold_used;
	int send_gap;
	int stall_left;
	int long_hold_left;
	int mismatches;
	int cycle_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void queue_result(logic [fpa_pkg::ST_W-1:0] st, int pg,
		logic [fpa_pkg::ID_W-1:0] owner, bit last);
		page_result_t r;
		r.status = st;
		r.page   = pg[fpa_pkg::PIDX_W-1:0];
		r.owner  = owner;
		r.last   = last;
		results_due = {results_due, r};
	endfunction

	function automatic void allocator_step(request_t rq);
		int                       need;
		int                       taken;
		logic [fpa_pkg::ID_W-1:0] victim;
		page_result_t             held;
		taken = 0;
		if (rq.kind == REQ_ALLOC) begin
			need = (int'(rq.len) + ID_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
			if (admit_count >= QUEUE_DEPTH) begin
				queue_result(fpa_pkg::ST_Q_FULL, 0, rq.pid, 1'b1);
			end else if (need > free_pages) begin
				queue_result(fpa_pkg::ST_NO_SPACE, 0, rq.pid, 1'b1);
			end else begin
				for (int k = 0; k < NUM_PAGES; k++) begin
					if (taken < need && page_is_free[k]) begin
						page_is_free[k] = 1'b0;
						page_tag[k] = rq.pid;
						free_pages--;
						taken++;
						queue_result(fpa_pkg::ST_ASSIGNED, k, rq.pid, taken == need);
					end
				end
				admit_fifo[admit_tail] = rq.pid;
				admit_tail = (admit_tail + 1) % QUEUE_DEPTH;
				admit_count++;
			end
		end else begin
			if (admit_count == 0) begin
				queue_result(fpa_pkg::ST_Q_EMPTY, 0, '0, 1'b1);
			end else begin
				victim = admit_fifo[admit_head];
				admit_head = (admit_head + 1) % QUEUE_DEPTH;
				admit_count--;
				for (int k = 0; k < NUM_PAGES; k++) begin
					if (!page_is_free[k] && page_tag[k] == victim) begin
						page_is_free[k] = 1'b1;
						free_pages++;
						if (taken > 0)
							results_due = {results_due, held};
						held.status = fpa_pkg::ST_FREED;
						held.page   = k[fpa_pkg::PIDX_W-1:0];
						held.owner  = victim;
						held.last   = 1'b0;
						taken++;
					end
				end
				if (taken == 0) begin
					queue_result(fpa_pkg::ST_NONE_FREED, 0, victim, 1'b1);
				end else begin
					held.last = 1'b1;
					results_due = {results_due, held};
				end
			end
		end
	endfunction

	task automatic note_mismatch(string what, page_result_t want, page_result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: want st=%0d pg=%0d id=%h last=%b, %s",
				$realtime, what, want.status, want.page, want.owner, want.last,
				$sformatf("got st=%0d pg=%0d id=%h last=%b",
					got.status, got.page, got.owner, got.last));
	endtask

	task automatic add_alloc(logic [fpa_pkg::ID_W-1:0] pid, logic [fpa_pkg::LEN_W-1:0] len);
		request_t rq;
		rq.kind = REQ_ALLOC;
		rq.pid  = pid;
		rq.len  = len;
		request_queue = {request_queue, rq};
	endtask

	task automatic add_release();
		request_t rq;
		rq.kind = REQ_RELEASE;
		rq.pid  = 16'($urandom_range(0, 65535));
		rq.len  = 20'($urandom);
		request_queue = {request_queue, rq};
	endtask

	function automatic request_t random_request();
		request_t rq;
		int       pick;
		rq.pid = 16'($urandom_range(0, 65535));
		rq.len = 20'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			rq.kind = REQ_RELEASE;
		end else begin
			rq.kind = REQ_ALLOC;
			if (recent_ids.size() != 0 && $urandom_range(0, 3) == 0)
				rq.pid = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
			pick = $urandom_range(0, 99);
			if (pick < 80)
				rq.len = 20'($urandom_range(0, 4 * PAGE_BYTES));
			else if (pick < 92)
				rq.len = 20'($urandom_range(0, NUM_PAGES * PAGE_BYTES - ID_BYTES));
			recent_ids = {recent_ids, rq.pid};
			if (recent_ids.size() > 8)
				void'(recent_ids.pop_front());
		end
		return rq;
	endfunction

	task automatic wait_drained();
		do
			@(posedge clk);
		while (!drained);
	endtask

	always @(posedge clk) begin : observe
		page_result_t got;
		page_result_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = rsp_ch.status;
				got.page   = rsp_ch.page_index;
				got.owner  = rsp_ch.owner_id;
				got.last   = rsp_ch.last;
				if (results_due.size() == 0) begin
					want = '{default: '0};
					note_mismatch("result with none due", want, got);
				end else begin
					want = results_due.pop_front();
					if (got.status !== want.status || got.page !== want.page ||
						got.owner !== want.owner || got.last !== want.last)
						note_mismatch("result mismatch", want, got);
				end
			end
			req_fire = req_ch.valid && req_ch.ready;
			if (req_fire)
				allocator_step('{req_kind_t'(req_ch.req_type), req_ch.process_id,
					req_ch.content_bytes});
		end else begin
			req_fire = 1'b0;
		end
	end

	always @(negedge clk) begin : drive_requests
		request_t item;
		if (arst_n) begin
			if (req_fire || !offering) begin
				if (send_gap > 0) begin
					send_gap--;
					offering = 1'b0;
				end else if (request_queue.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 7);
					offering = 1'b0;
				end else if (request_queue.size() != 0) begin
					item = request_queue.pop_front();
					req_ch.req_type      <= item.kind;
					req_ch.process_id    <= item.pid;
					req_ch.content_bytes <= item.len;
					offering = 1'b1;
				end else begin
					offering = 1'b0;
				end
				req_ch.valid <= offering;
			end
			drained = request_queue.size() == 0 && !offering && results_due.size() == 0;
		end
	end

	always @(negedge clk) begin : drive_ready
		if (arst_n) begin
			if (long_hold_go && !long_hold_used) begin
				long_hold_used = 1'b1;
				long_hold_left = LONG_HOLD;
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 7);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		for (cycle_count = 0; cycle_count < LIMIT; cycle_count++)
			@(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_ALLOC;
		req_ch.process_id    = '0;
		req_ch.content_bytes = '0;
		rsp_ch.ready         = 1'b0;
		for (int k = 0; k < NUM_PAGES; k++)
			page_is_free[k] = 1'b1;
		free_pages  = NUM_PAGES;
		admit_head  = 0;
		admit_tail  = 0;
		admit_count = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_release();
		add_alloc(16'h0000, 20'd0);
		add_alloc(16'hFFFF, 20'd4092);
		add_alloc(16'h1234, 20'd4093);
		add_alloc(16'h00AA, 20'hFFFFF);
		add_alloc(16'h1234, 20'd8188);
		add_release();
		add_release();
		add_release();
		add_release();
		add_release();
		add_alloc(16'h5555, 20'(NUM_PAGES * PAGE_BYTES - ID_BYTES));
		add_alloc(16'hAAAA, 20'd0);
		add_release();
		add_alloc(16'h0F0F, 20'(NUM_PAGES * PAGE_BYTES - ID_BYTES + 1));
		add_alloc(16'hF0F0, 20'h55555);
		add_alloc(16'h0FF0, 20'hAAAAA);
		add_release();
		add_alloc(16'h0101, 20'd0);
		add_alloc(16'h0202, 20'd4096);
		add_alloc(16'h0303, 20'd0);
		add_release();
		add_alloc(16'h0404, 20'd8192);
		add_release();
		add_release();
		add_release();
		wait_drained();

		// hold results back at the start of a run that takes every page and queue slot, plus one request more
		long_hold_go = 1'b1;
		for (int n = 0; n < QUEUE_DEPTH; n++)
			add_alloc(16'($urandom_range(0, 65535)),
				20'($urandom_range(0, PAGE_BYTES - ID_BYTES)));
		add_alloc(16'($urandom_range(0, 65535)),
			20'($urandom_range(0, PAGE_BYTES - ID_BYTES)));
		wait_drained();

		for (int n = 0; n < 220; n++)
			request_queue = {request_queue, random_request()};
		wait_drained();

		calm = 1'b1;
		for (int n = 0; n < 50; n++)
			request_queue = {request_queue, random_request()};
		wait_drained();
		repeat (NUM_PAGES + 16) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
